FILE: hw/rtl/dmlr_pkg.sv
// ----------------------------------------------------------------------------
// dmlr_pkg
// shared widths and divider request / response types for the downmix
// linear resampler
// ----------------------------------------------------------------------------
`default_nettype none

package dmlr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int RUN_CAP      = 64;

    localparam int RATE_W  = 19;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 32;
    localparam int OUTS_W  = 40;
    localparam int SUM_W   = SAMPLE_BITS + 3;

    localparam int DIV_W   = 60;
    localparam int DIVR_W  = 20;
    localparam int STEP_W  = $clog2(DIV_W);

    localparam int RUN_W   = $clog2(RUN_CAP + 1);
    localparam int K_W     = $clog2(RUN_CAP);

    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE_RATE   = 2'd1;
    localparam logic [1:0] REG_TARGET_RATE   = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIVR_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmlr_div.sv
// ----------------------------------------------------------------------------
// dmlr_div
// restoring radix-2 divider, one quotient bit per cycle, shared by all
// divisions of the resampler
// ----------------------------------------------------------------------------
`default_nettype none

module dmlr_div
    import dmlr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_W-1:0]  quo_reg;
    logic [DIVR_W:0]   rem_reg;
    logic [DIVR_W-1:0] dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVR_W:0]   shifted;
    logic [DIVR_W+1:0] trial;

    assign shifted = {rem_reg[DIVR_W-1:0], quo_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVR_W+1])
            begin
                rem_reg <= trial[DIVR_W:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[DIVR_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/downmix_linear_resampler.sv
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// averages up to eight channels to mono and resamples by linear
// interpolation, one source frame per input transfer
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        sink       in_valid/in_stall   chan_a..chan_h, final_frame
// out       source     out_valid/out_stall mono_out, run_end, clip_end, cut_flag
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// every division runs on one shared bit-serial divider with a 60-bit dividend
// a frame runs the downmix division, the run-length division, per result a
// position division (plus a fraction division to interpolate), then closes
// in_stall is high from the accepted transfer until the frame's run is done
// out_stall only holds the result register; the next result waits behind it
// reset is asynchronous and gives the register reset values and an empty clip
// ----------------------------------------------------------------------------
`default_nettype none

module downmix_linear_resampler
    import dmlr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [RATE_W-1:0]      cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_a,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_b,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_c,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_d,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_e,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_f,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_g,
    input  wire logic signed [SAMPLE_BITS-1:0] chan_h,
    input  wire logic                   final_frame,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [SAMPLE_BITS-1:0] mono_out,
    output logic                        run_end,
    output logic                        clip_end,
    output logic                        cut_flag
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MONO_GO   = 4'd1;
    localparam logic [3:0] S_MONO_WAIT = 4'd2;
    localparam logic [3:0] S_DECIDE    = 4'd3;
    localparam logic [3:0] S_END_GO    = 4'd4;
    localparam logic [3:0] S_END_WAIT  = 4'd5;
    localparam logic [3:0] S_RUN       = 4'd6;
    localparam logic [3:0] S_NUM_MUL   = 4'd7;
    localparam logic [3:0] S_Q_GO      = 4'd8;
    localparam logic [3:0] S_Q_WAIT    = 4'd9;
    localparam logic [3:0] S_T_GO      = 4'd10;
    localparam logic [3:0] S_T_WAIT    = 4'd11;
    localparam logic [3:0] S_INTERP    = 4'd12;
    localparam logic [3:0] S_EMIT      = 4'd13;
    localparam logic [3:0] S_FINISH    = 4'd14;

    logic [3:0]        state_reg;

    logic [CNT_W-1:0]  channel_count_reg;
    logic [RATE_W-1:0] source_rate_reg;
    logic [RATE_W-1:0] target_rate_reg;

    logic signed [SAMPLE_BITS-1:0] held_mono_reg;
    logic [IDX_W-1:0]  frames_seen_reg;
    logic [OUTS_W-1:0] outputs_made_reg;

    logic [SUM_W-1:0]  abs_sum_reg;
    logic              sum_neg_reg;
    logic [CNT_W-1:0]  nch_reg;
    logic              fin_reg;
    logic signed [SAMPLE_BITS-1:0] mono_reg;
    logic              pass_reg;
    logic              first_reg;
    logic [DIV_W-1:0]  prod_reg;
    logic [DIV_W-1:0]  end_reg;
    logic              any_reg;
    logic              cut_reg;
    logic [RUN_W-1:0]  emitn_reg;
    logic [K_W-1:0]    k_reg;
    logic [DIVR_W-1:0] r_reg;
    logic signed [41:0] ip_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg;

    logic              out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] mono_out_reg;
    logic              run_end_reg;
    logic              clip_end_reg;
    logic              cut_flag_reg;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [RATE_W-1:0] s_eff;
    logic [CNT_W-1:0]  nch_eff;
    logic signed [SAMPLE_BITS-1:0] chans [MAX_CHANNELS];
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]  sum_mag;
    logic              in_xfer;
    logic              out_xfer;
    logic              load_out;
    logic [DIV_W-1:0]  run_count;
    logic              last_k;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SAMPLE_BITS+1:0] interp;

    assign s_eff   = (source_rate_reg == '0) ? RATE_W'(1) : source_rate_reg;
    assign nch_eff = (channel_count_reg == '0) ? CNT_W'(1) :
                     (channel_count_reg > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) :
                     channel_count_reg;

    assign chans[0] = chan_a;
    assign chans[1] = chan_b;
    assign chans[2] = chan_c;
    assign chans[3] = chan_d;
    assign chans[4] = chan_e;
    assign chans[5] = chan_f;
    assign chans[6] = chan_g;
    assign chans[7] = chan_h;

    always_comb
    begin
        sum = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (CNT_W'(c) < nch_eff)
            begin
                sum = sum + SUM_W'(chans[c]);
            end
        end
    end

    assign sum_mag   = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign load_out  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign last_k    = ({1'b0, k_reg} == emitn_reg - RUN_W'(1));
    assign run_count = (end_reg > DIV_W'(outputs_made_reg)) ?
                       (end_reg - DIV_W'(outputs_made_reg)) : '0;
    assign diff      = {mono_reg[SAMPLE_BITS-1], mono_reg}
                     - {held_mono_reg[SAMPLE_BITS-1], held_mono_reg};
    assign interp    = {{2{held_mono_reg[SAMPLE_BITS-1]}}, held_mono_reg}
                     + ip_reg[41:FRAC_BITS];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(abs_sum_reg);
        div_req.divisor  = DIVR_W'(nch_reg);
        unique case (state_reg)
            S_MONO_GO:
            begin
                div_req.start = 1'b1;
            end
            S_END_GO:
            begin
                div_req.start = 1'b1;
                if (fin_reg)
                begin
                    div_req.dividend = {prod_reg[DIV_W-2:0], 1'b0} + DIV_W'(s_eff);
                    div_req.divisor  = {s_eff, 1'b0};
                end
                else
                begin
                    div_req.dividend = prod_reg + DIV_W'(s_eff) - DIV_W'(1);
                    div_req.divisor  = DIVR_W'(s_eff);
                end
            end
            S_Q_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = DIVR_W'(target_rate_reg);
            end
            S_T_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({r_reg, {FRAC_BITS{1'b0}}});
                div_req.divisor  = DIVR_W'(target_rate_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    dmlr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CNT_W'(1);
            source_rate_reg   <= RATE_W'(48000);
            target_rate_reg   <= RATE_W'(16000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CNT_W-1:0];
                REG_SOURCE_RATE:   source_rate_reg   <= cfg_data;
                REG_TARGET_RATE:   target_rate_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            held_mono_reg    <= '0;
            frames_seen_reg  <= '0;
            outputs_made_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_MONO_GO;
                    end
                end
                S_MONO_GO:
                begin
                    state_reg <= S_MONO_WAIT;
                end
                S_MONO_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (pass_reg || first_reg)
                    begin
                        state_reg <= pass_reg ? S_EMIT : S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_END_GO;
                    end
                end
                S_END_GO:
                begin
                    state_reg <= S_END_WAIT;
                end
                S_END_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    state_reg <= (run_count == '0) ? S_FINISH : S_NUM_MUL;
                end
                S_NUM_MUL:
                begin
                    state_reg <= S_Q_GO;
                end
                S_Q_GO:
                begin
                    state_reg <= S_Q_WAIT;
                end
                S_Q_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= (div_rsp.quotient < DIV_W'(frames_seen_reg)) ?
                                     S_T_GO : S_EMIT;
                    end
                end
                S_T_GO:
                begin
                    state_reg <= S_T_WAIT;
                end
                S_T_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_INTERP;
                    end
                end
                S_INTERP:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (load_out)
                    begin
                        state_reg <= (pass_reg || last_k) ? S_FINISH : S_NUM_MUL;
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    if (pass_reg)
                    begin
                        held_mono_reg    <= mono_reg;
                        frames_seen_reg  <= frames_seen_reg + IDX_W'(1);
                        outputs_made_reg <= outputs_made_reg + OUTS_W'(1);
                    end
                    else if (first_reg)
                    begin
                        held_mono_reg    <= mono_reg;
                        frames_seen_reg  <= IDX_W'(1);
                        outputs_made_reg <= '0;
                    end
                    else
                    begin
                        held_mono_reg   <= mono_reg;
                        frames_seen_reg <= frames_seen_reg + IDX_W'(1);
                        if (any_reg)
                        begin
                            outputs_made_reg <= end_reg[OUTS_W-1:0];
                        end
                    end
                    if (fin_reg)
                    begin
                        held_mono_reg    <= '0;
                        frames_seen_reg  <= '0;
                        outputs_made_reg <= '0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                abs_sum_reg <= sum_mag;
                sum_neg_reg <= sum[SUM_W-1];
                nch_reg     <= nch_eff;
                fin_reg     <= final_frame;
                k_reg       <= '0;
            end
            S_MONO_WAIT:
            begin
                mono_reg  <= sum_neg_reg ? (~div_rsp.quotient[SAMPLE_BITS-1:0]
                                            + SAMPLE_BITS'(1))
                                         : div_rsp.quotient[SAMPLE_BITS-1:0];
                pass_reg  <= (target_rate_reg == '0) || (target_rate_reg == s_eff)
                          || (fin_reg && (frames_seen_reg == '0));
                first_reg <= (frames_seen_reg == '0);
            end
            S_DECIDE:
            begin
                val_reg   <= mono_reg;
                cut_reg   <= 1'b0;
                emitn_reg <= RUN_W'(1);
                if (fin_reg)
                begin
                    prod_reg <= DIV_W'((IDX_W+1)'(frames_seen_reg) + (IDX_W+1)'(1))
                              * DIV_W'(target_rate_reg);
                end
                else
                begin
                    prod_reg <= DIV_W'(frames_seen_reg) * DIV_W'(target_rate_reg);
                end
            end
            S_END_WAIT:
            begin
                end_reg <= div_rsp.quotient;
            end
            S_RUN:
            begin
                any_reg   <= (run_count != '0);
                cut_reg   <= (run_count > DIV_W'(RUN_CAP));
                emitn_reg <= (run_count > DIV_W'(RUN_CAP)) ? RUN_W'(RUN_CAP)
                                                           : run_count[RUN_W-1:0];
            end
            S_NUM_MUL:
            begin
                prod_reg <= DIV_W'((OUTS_W+1)'(outputs_made_reg) + (OUTS_W+1)'(k_reg))
                          * DIV_W'(s_eff);
            end
            S_Q_WAIT:
            begin
                r_reg <= div_rsp.remainder;
                if (div_rsp.quotient == DIV_W'(frames_seen_reg))
                begin
                    val_reg <= mono_reg;
                end
                else
                begin
                    val_reg <= '0;
                end
            end
            S_T_WAIT:
            begin
                ip_reg <= 42'(diff) * 42'($signed({1'b0, div_rsp.quotient[FRAC_BITS-1:0]}));
            end
            S_INTERP:
            begin
                val_reg <= interp[SAMPLE_BITS-1:0];
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    k_reg <= k_reg + K_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            mono_out_reg <= val_reg;
            run_end_reg  <= pass_reg || last_k;
            clip_end_reg <= (pass_reg || last_k) && fin_reg;
            cut_flag_reg <= cut_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign mono_out  = mono_out_reg;
    assign run_end   = run_end_reg;
    assign clip_end  = clip_end_reg;
    assign cut_flag  = cut_flag_reg;

endmodule

`default_nettype wire
